>>> hdl/pi_controller_antiwindup_top_assert.svh
// Assertion macros for the PI regulator.
`ifndef PI_CONTROLLER_ANTIWINDUP_TOP_ASSERT_SVH
`define PI_CONTROLLER_ANTIWINDUP_TOP_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while reset is low.
`define PICA_ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while reset is low.
`define PICA_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> hdl/pica_pkg.sv
// Shared constants and types of the PI regulator.
package pica_pkg;

    localparam int CFG_CHANNELS = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int ADDR_W       = 5;
    localparam int DATA_W       = 32;

    localparam logic [CFG_IDX_W-1:0] REG_KP_FIRST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI_FIRST   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KP_SECOND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KI_SECOND  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_SECOND = 3'd5;

    localparam int GAIN_W = 8;
    localparam logic [GAIN_W-1:0] KP_RESET  = 8'd20;
    localparam logic [GAIN_W-1:0] KI_RESET  = 8'd200;
    localparam logic              DIR_RESET = 1'b1;

    localparam int IN_W       = 16;
    localparam int ERR_W      = 17;
    localparam int PROD_W     = 25;
    localparam int PROD_MAG_W = 24;
    localparam int PQ_W       = 9;
    localparam int DVS_W      = 14;
    localparam int DRIVE_W    = 7;

    localparam int KI_DIV_SCALE     = 40;
    localparam int P_CLAMP_QUARTERS = 400;
    localparam int DRIVE_FULL       = 100;

    typedef struct packed {
        logic busy;
        logic done;
        logic ovf;
    } pica_div_stat_t;

endpackage

>>> hdl/pi_controller_antiwindup_top.sv
// Two-channel PI regulator with anti-windup clamp and APB register port.
// Sequence: multiply, prepare, divide in the bit-serial divider, sum, output; the divide is
//   skipped when the product is negative or zero or the integral code is zero.
// A new input beat is taken only in idle, once the last result has been loaded to the output;
//   a stalled result holds the input off.
// Reset: gains 20/200, direct mode, both integrals zero; no clearing pass.
`include "pi_controller_antiwindup_top_assert.svh"

module pi_controller_antiwindup_top import pica_pkg::*; #(
    parameter int CHANNELS  = 2,
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_channel,
    input  logic signed [IN_W-1:0]   s_measured,
    input  logic signed [IN_W-1:0]   s_target,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [DRIVE_W-1:0]       m_drive
);

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DVD_W    = PROD_MAG_W + FRAC_BITS;
    localparam int QUO_W    = FRAC_BITS + 9;
    localparam int P_W      = FRAC_BITS + 7;
    localparam int I_W      = FRAC_BITS + 8;
    localparam int BASE_W   = FRAC_BITS + 9;
    localparam int UD_W     = FRAC_BITS + 11;
    localparam logic [P_W-1:0] FULL = P_W'(DRIVE_FULL) << FRAC_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]               state_reg, state_next;

    logic [GAIN_W-1:0]        kp_reg  [CFG_CHANNELS];
    logic [GAIN_W-1:0]        ki_reg  [CFG_CHANNELS];
    logic                     dir_reg [CFG_CHANNELS];
    logic signed [I_W-1:0]    integ_mem_reg [CHANNELS];

    logic                     ch_reg;
    logic                     ch_ok_reg;
    logic [GAIN_W-1:0]        kp_sel_reg;
    logic [GAIN_W-1:0]        ki_sel_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [I_W-1:0]    integ_rd_reg;
    logic [P_W-1:0]           p_reg;
    logic signed [BASE_W-1:0] base_reg;
    logic                     skip_reg;
    logic [P_W-1:0]           ud_reg;
    logic                     m_valid_reg;
    logic [DRIVE_W-1:0]       m_drive_reg;

    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_idx;
    logic                     in_take;
    logic                     out_load;
    logic [CH_IDX_W-1:0]      ch_idx;
    logic                     ch_ok_c;
    logic signed [ERR_W-1:0]  meas_x, tgt_x, err_c;
    logic signed [PROD_W-1:0] kp_x, err_x, prod_c;
    logic                     neg_c, skip_c;
    logic [P_W-1:0]           p_c;
    logic signed [BASE_W-1:0] base_c;
    logic [DVD_W-1:0]         dividend_c;
    logic [DVS_W-1:0]         divisor_c;
    logic [QUO_W-1:0]         inc_c;
    logic signed [UD_W-1:0]   ud_c;
    logic [P_W-1:0]           ud_clamp_c;
    logic signed [I_W-1:0]    integ_new;
    logic                     integ_in_range;
    logic                     div_start;
    pica_div_stat_t           div_stat;
    logic [QUO_W-1:0]         div_quo;

    // Register port
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < CFG_CHANNELS; k++) begin
                kp_reg[k]  <= KP_RESET;
                ki_reg[k]  <= KI_RESET;
                dir_reg[k] <= DIR_RESET;
            end
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_KP_FIRST:   kp_reg[0]  <= pwdata[GAIN_W-1:0];
                REG_KI_FIRST:   ki_reg[0]  <= pwdata[GAIN_W-1:0];
                REG_DIR_FIRST:  dir_reg[0] <= pwdata[0];
                REG_KP_SECOND:  kp_reg[1]  <= pwdata[GAIN_W-1:0];
                REG_KI_SECOND:  ki_reg[1]  <= pwdata[GAIN_W-1:0];
                REG_DIR_SECOND: dir_reg[1] <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_KP_FIRST:   prdata = DATA_W'(kp_reg[0]);
            REG_KI_FIRST:   prdata = DATA_W'(ki_reg[0]);
            REG_DIR_FIRST:  prdata = DATA_W'(dir_reg[0]);
            REG_KP_SECOND:  prdata = DATA_W'(kp_reg[1]);
            REG_KI_SECOND:  prdata = DATA_W'(ki_reg[1]);
            REG_DIR_SECOND: prdata = DATA_W'(dir_reg[1]);
            default:        prdata = '0;
        endcase
    end

    // Handshakes
    assign s_ready  = (state_reg == S_IDLE);
    assign in_take  = s_valid && s_ready;
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_ready);
    assign m_valid  = m_valid_reg;
    assign m_drive  = m_drive_reg;

    // Datapath
    assign ch_idx  = CH_IDX_W'(ch_reg);
    assign ch_ok_c = (int'(s_channel) < CHANNELS);
    assign meas_x  = ERR_W'(s_measured);
    assign tgt_x   = ERR_W'(s_target);
    assign err_c   = dir_reg[s_channel] ? (tgt_x - meas_x) : (meas_x - tgt_x);

    assign kp_x   = $signed(PROD_W'(kp_sel_reg));
    assign err_x  = PROD_W'(err_reg);
    assign prod_c = kp_x * err_x;

    assign neg_c  = prod_reg[PROD_W-1];
    assign skip_c = neg_c || (ki_sel_reg == '0) || (prod_reg == '0);

    always_comb begin
        if (neg_c) begin
            p_c = '0;
        end else if (prod_reg > $signed(PROD_W'(P_CLAMP_QUARTERS))) begin
            p_c = FULL;
        end else begin
            p_c = P_W'(prod_reg[PQ_W-1:0]) << (FRAC_BITS - 2);
        end
    end

    assign base_c     = neg_c ? '0 : ($signed(BASE_W'(p_c)) + BASE_W'(integ_rd_reg));
    assign dividend_c = {prod_reg[PROD_MAG_W-1:0], {FRAC_BITS{1'b0}}};
    assign divisor_c  = DVS_W'(DVS_W'(ki_sel_reg) * DVS_W'(KI_DIV_SCALE));
    assign div_start  = (state_reg == S_PREP) && !skip_c;

    assign inc_c = skip_reg ? '0 : (div_stat.ovf ? '1 : div_quo);
    assign ud_c  = UD_W'(base_reg) + $signed(UD_W'(inc_c));

    always_comb begin
        if (ud_c < 0) begin
            ud_clamp_c = '0;
        end else if (ud_c > $signed(UD_W'(FULL))) begin
            ud_clamp_c = FULL;
        end else begin
            ud_clamp_c = ud_c[P_W-1:0];
        end
    end

    assign integ_new      = $signed(I_W'(ud_reg)) - $signed(I_W'(p_reg));
    assign integ_in_range = (integ_new >= -$signed(I_W'(FULL)))
                            && (integ_new <= $signed(I_W'(FULL)));

    pica_div #(
        .DVD_W (DVD_W),
        .QUO_W (QUO_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend_c),
        .divisor  (divisor_c),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_take) state_next = S_MUL;
            S_MUL:  state_next = S_PREP;
            S_PREP: state_next = skip_c ? S_SUM : S_WAIT;
            S_WAIT: if (div_stat.done) state_next = S_SUM;
            S_SUM:  state_next = S_OUT;
            S_OUT:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < CHANNELS; k++) begin
                integ_mem_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (out_load && ch_ok_reg) begin
                integ_mem_reg[ch_idx] <= integ_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            ch_reg     <= s_channel;
            ch_ok_reg  <= ch_ok_c;
            kp_sel_reg <= kp_reg[s_channel];
            ki_sel_reg <= ki_reg[s_channel];
            err_reg    <= err_c;
        end
        if (state_reg == S_MUL) begin
            prod_reg     <= prod_c;
            integ_rd_reg <= ch_ok_reg ? integ_mem_reg[ch_idx] : '0;
        end
        if (state_reg == S_PREP) begin
            p_reg    <= p_c;
            base_reg <= base_c;
            skip_reg <= skip_c;
        end
        if (state_reg == S_SUM) begin
            ud_reg <= ud_clamp_c;
        end
        if (out_load) begin
            m_drive_reg <= ch_ok_reg ? ud_reg[FRAC_BITS +: DRIVE_W] : '0;
        end
    end

    // Checks
    `PICA_ASSERT_IMPLY(a_drive_range, m_valid, m_drive <= DRIVE_W'(DRIVE_FULL), "drive above full scale")
    `PICA_ASSERT_IMPLY(a_done_in_wait, div_stat.done, state_reg == S_WAIT, "divider done outside wait")
    `PICA_ASSERT_IMPLY(a_wait_busy, state_reg == S_WAIT, div_stat.busy || div_stat.done, "wait with idle divider")
    `PICA_ASSERT_IMPLY(a_integ_range, out_load && ch_ok_reg, integ_in_range, "integral out of range")
    `PICA_ASSERT_NEXT(a_bad_channel_zero, out_load && !ch_ok_reg, m_drive == '0, "absent channel drive not zero")

endmodule

>>> hdl/pica_div.sv
// Bit-serial restoring divider with a quotient overflow flag; the caller saturates.
module pica_div import pica_pkg::*; #(
    parameter int DVD_W = 40,
    parameter int QUO_W = 25
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DVD_W-1:0]     dividend,
    input  logic [DVS_W-1:0]     divisor,
    output pica_div_stat_t       stat,
    output logic [QUO_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [QUO_W-1:0] quo_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_diff;
    logic             ge;

    assign rem_sh   = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_diff = rem_sh - {1'b0, dvs_reg};
    assign ge       = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= ge ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
            ovf_reg <= ovf_reg | quo_reg[QUO_W-1];
        end
    end

    assign stat     = '{busy: busy_reg, done: done_reg, ovf: ovf_reg};
    assign quotient = quo_reg;

endmodule

>>> sim/pica_drive_check.sv
`timescale 1ns / 1ps
// Drive predictor and result comparison for the PI regulator testbench.
module pica_drive_check import pica_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    input  logic                   pready,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic                   s_channel,
    input  logic signed [IN_W-1:0] s_measured,
    input  logic signed [IN_W-1:0] s_target,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [DRIVE_W-1:0]     m_drive,
    output int                     fail_count,
    output int                     pending,
    output int                     checked
);

    logic [GAIN_W-1:0]  kp_cfg [CFG_CHANNELS];
    logic [GAIN_W-1:0]  ki_cfg [CFG_CHANNELS];
    logic               dir_cfg [CFG_CHANNELS];
    longint             integ_acc [CFG_CHANNELS];
    logic [DRIVE_W-1:0] drive_due_q [$];
    logic [DRIVE_W-1:0] want;

    function automatic logic [DRIVE_W-1:0] predict_drive(input int unsigned ch,
            input logic signed [IN_W-1:0] meas, input logic signed [IN_W-1:0] tgt);
        longint one, full, err, prod, p, acc, ud;
        logic [DRIVE_W-1:0] pct;
        one  = longint'(1) << FRAC_BITS;
        full = longint'(DRIVE_FULL) * one;
        err  = dir_cfg[ch] ? longint'(tgt) - longint'(meas) : longint'(meas) - longint'(tgt);
        prod = longint'(kp_cfg[ch]) * err;
        acc  = integ_acc[ch];
        if (prod < 0) begin
            p   = 0;
            acc = 0;
        end else if (prod > P_CLAMP_QUARTERS) begin
            p = full;
        end else begin
            p = prod * (one / 4);
        end
        if (ki_cfg[ch] != 0)
            acc += (prod * one) / (longint'(KI_DIV_SCALE) * longint'(ki_cfg[ch]));
        ud = p + acc;
        if (ud < 0)
            ud = 0;
        else if (ud > full)
            ud = full;
        integ_acc[ch] = ud - p;
        pct = DRIVE_W'(ud / one);
        return pct;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < CFG_CHANNELS; k++) begin
                kp_cfg[k]    = KP_RESET;
                ki_cfg[k]    = KI_RESET;
                dir_cfg[k]   = DIR_RESET;
                integ_acc[k] = 0;
            end
            drive_due_q.delete();
            pending = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (drive_due_q.size() == 0) begin
                    $error("drive: unexpected result %0d with no sample outstanding", m_drive);
                    fail_count++;
                end else begin
                    want = drive_due_q.pop_front();
                    if (m_drive !== want) begin
                        $error("drive mismatch: expected %0d, actual %0d", want, m_drive);
                        fail_count++;
                    end
                    checked++;
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_KP_FIRST:   kp_cfg[0]  = pwdata[GAIN_W-1:0];
                    REG_KI_FIRST:   ki_cfg[0]  = pwdata[GAIN_W-1:0];
                    REG_DIR_FIRST:  dir_cfg[0] = pwdata[0];
                    REG_KP_SECOND:  kp_cfg[1]  = pwdata[GAIN_W-1:0];
                    REG_KI_SECOND:  ki_cfg[1]  = pwdata[GAIN_W-1:0];
                    REG_DIR_SECOND: dir_cfg[1] = pwdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                drive_due_q.push_back(predict_drive(32'(s_channel), s_measured, s_target));
            pending = drive_due_q.size();
        end
    end

endmodule

>>> sim/tb_pi_controller_antiwindup_top.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, register setup, sample stimulus and verdict.
module tb_pi_controller_antiwindup_top;
    import pica_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int PHASES    = 8;
    localparam int PHASE_LEN = 200;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                   aclk;
    logic                   aresetn    = 1'b0;
    logic                   psel       = 1'b0;
    logic                   penable    = 1'b0;
    logic                   pwrite     = 1'b0;
    logic [ADDR_W-1:0]      paddr      = '0;
    logic [DATA_W-1:0]      pwdata     = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;
    logic                   s_valid    = 1'b0;
    logic                   s_ready;
    logic                   s_channel  = 1'b0;
    logic signed [IN_W-1:0] s_measured = '0;
    logic signed [IN_W-1:0] s_target   = '0;
    logic                   m_valid;
    logic                   m_ready    = 1'b0;
    logic [DRIVE_W-1:0]     m_drive;

    int   fail_count;
    int   pending;
    int   checked;
    int   sent     = 0;
    int   settings = 1;
    logic gaps_on  = 1'b1;

    pi_controller_antiwindup_top #(
        .CHANNELS  (2),
        .FRAC_BITS (FRAC_BITS)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_channel  (s_channel),
        .s_measured (s_measured),
        .s_target   (s_target),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_drive    (m_drive)
    );

    pica_drive_check #(
        .FRAC_BITS (FRAC_BITS)
    ) u_drive_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_channel  (s_channel),
        .s_measured (s_measured),
        .s_target   (s_target),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_drive    (m_drive),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(negedge aclk) begin
        if (!gaps_on)
            m_ready <= 1'b1;
        else
            m_ready <= ($urandom_range(99) >= 12);
    end

    // Enter and leave at a falling edge.
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // Enter at a falling edge; leave at the falling edge after the beat, valid still high.
    task automatic send_sample(input logic ch, input logic signed [IN_W-1:0] meas,
            input logic signed [IN_W-1:0] tgt);
        if (gaps_on && $urandom_range(99) < 12) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_channel  <= ch;
        s_measured <= meas;
        s_target   <= tgt;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        sent++;
    endtask

    // Drop valid and hold until every drive result has come back.
    task automatic settle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(5))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'hFF;
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    task automatic load_gains(input logic [GAIN_W-1:0] kp0, input logic [GAIN_W-1:0] ki0,
            input logic dir0, input logic [GAIN_W-1:0] kp1, input logic [GAIN_W-1:0] ki1,
            input logic dir1);
        reg_write(REG_KP_FIRST, DATA_W'(kp0));
        reg_write(REG_KI_FIRST, DATA_W'(ki0));
        reg_write(REG_DIR_FIRST, DATA_W'(dir0));
        reg_write(REG_KP_SECOND, DATA_W'(kp1));
        reg_write(REG_KI_SECOND, DATA_W'(ki1));
        reg_write(REG_DIR_SECOND, DATA_W'(dir1));
        settings++;
    endtask

    task automatic random_samples(input int count);
        int                     sel;
        int                     delta;
        int                     m;
        logic signed [IN_W-1:0] tgt;
        logic signed [IN_W-1:0] meas;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            tgt = IN_W'($urandom);
            // Mostly near the setpoint so the integral does real work.
            if (sel < 55)
                delta = int'($urandom_range(100)) - 50;
            else if (sel < 80)
                delta = int'($urandom_range(4000)) - 2000;
            else
                delta = 0;
            if (sel < 80) begin
                m = int'(tgt) + delta;
                if (m > 32767)
                    m = 32767;
                else if (m < -32768)
                    m = -32768;
                meas = m[IN_W-1:0];
            end else begin
                meas = IN_W'($urandom);
            end
            send_sample(1'($urandom_range(1)), meas, tgt);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_sample(1'b0, 16'sd0, 16'sd0);
        send_sample(1'b0, 16'sd0, 16'sd10);
        send_sample(1'b0, 16'sd0, 16'sd10);
        send_sample(1'b0, -16'sd32768, 16'sd32767);
        send_sample(1'b0, 16'sd32767, -16'sd32768);
        send_sample(1'b1, 16'sd32767, 16'sd32767);
        send_sample(1'b1, -16'sd32768, -16'sd32768);
        send_sample(1'b1, 16'sd100, 16'sd120);
        send_sample(1'b1, 16'sd100, 16'sd121);
        send_sample(1'b1, 16'sd5, 16'sd4);
        send_sample(1'b0, -16'sd1, 16'sd0);
        settle();

        // Zero integral code, reverse mode, zero gain; spare addresses must be ignored.
        load_gains(8'hFF, 8'd0, 1'b0, 8'd0, 8'hFF, 1'b0);
        reg_write(REG_SPARE_LO, 32'hFFFF_FFFF);
        reg_write(REG_SPARE_HI, 32'hFFFF_FFFF);
        send_sample(1'b0, 16'sd10, 16'sd0);
        send_sample(1'b0, 16'sd0, 16'sd1);
        send_sample(1'b0, 16'sd1, 16'sd0);
        send_sample(1'b1, 16'sd32767, -16'sd32768);
        send_sample(1'b1, -16'sd32768, 16'sd32767);
        settle();

        load_gains(8'd1, 8'd1, 1'b1, 8'hFF, 8'd1, 1'b1);
        send_sample(1'b1, 16'sd0, 16'sd1);
        send_sample(1'b1, 16'sd0, 16'sd1);
        send_sample(1'b1, 16'sd0, 16'sd1);
        send_sample(1'b0, 16'sd0, 16'sd400);
        send_sample(1'b0, 16'sd0, 16'sd399);
        send_sample(1'b1, 16'sd1, 16'sd0);
        settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            gaps_on <= !(ph == 3 || ph == 4);
            load_gains(pick_gain(), pick_gain(), 1'($urandom_range(1)),
                       pick_gain(), pick_gain(), 1'($urandom_range(1)));
            random_samples(PHASE_LEN);
            settle();
        end

        repeat (60) @(negedge aclk);
        $display("Sent %0d samples under %0d gain settings; %0d drive results compared.",
                 sent, settings, checked);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/pica_pkg.sv
hdl/pica_div.sv
hdl/pi_controller_antiwindup_top.sv
sim/pica_drive_check.sv
sim/tb_pi_controller_antiwindup_top.sv
